// ----- design/acked_route_transmit_tracker_macros.svh -----
// Assertion macros of the acked route transmit tracker, used by art_ctrl
`ifndef ACKED_ROUTE_TRANSMIT_TRACKER_MACROS_SVH
`define ACKED_ROUTE_TRANSMIT_TRACKER_MACROS_SVH

// check a consequence in the same cycle
`define ART_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the next cycle
`define ART_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/art_pkg.sv -----
// Types and constants of the acked route transmit tracker
`default_nettype none
package art_pkg;

    localparam int ROUTES       = 4;
    localparam int MAX_OUT      = 4;
    localparam int HEADER_BYTES = 3;

    localparam logic [2:0] ROUTE_CAP = 3'(ROUTES);
    localparam logic [2:0] OUT_CAP   = 3'(MAX_OUT);

    localparam logic [2:0] FN_WRITE  = 3'd0;
    localparam logic [2:0] FN_TICK   = 3'd1;
    localparam logic [2:0] FN_ACK    = 3'd2;
    localparam logic [2:0] FN_ADD    = 3'd3;
    localparam logic [2:0] FN_REMOVE = 3'd4;

    localparam logic [1:0] TX_IDLE       = 2'd0;
    localparam logic [1:0] TX_FRESH      = 2'd1;
    localparam logic [1:0] TX_WAIT       = 2'd2;
    localparam logic [1:0] TX_WAIT_FRESH = 2'd3;

    localparam logic CFG_MAX_DATA   = 1'b0;
    localparam logic CFG_MAX_PACKET = 1'b1;

    localparam logic [10:0] MAX_DATA_RST   = 11'd128;
    localparam logic [10:0] MAX_PACKET_RST = 11'd256;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  data_len;
        logic [31:0] now_ms;
        logic [2:0]  slots_free;
        logic [7:0]  ack_tag;
        logic        route_mode;
        logic [31:0] route_timeout;
        logic [9:0]  path_len;
        logic [1:0]  route_index;
    } t_in;

    typedef struct packed {
        logic [1:0] result_route;
        logic       transmitted;
        logic       with_tag;
        logic [7:0] tag_value;
        logic       oversize_drop;
        logic       op_ok;
        logic [1:0] new_index;
        logic       clear_to_write;
        logic       last;
    } t_out;

    typedef struct packed {
        logic        idx;
        logic [10:0] wdata;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic serve;
        logic finish;
        logic out_pop;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic scan_done;
        logic serve_done;
        logic out_last;
    } t_sts;

endpackage
`default_nettype wire

// ----- design/art_if.sv -----
// Handshake channel interfaces of the acked route transmit tracker
`default_nettype none
interface art_in_if;
    import art_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface art_out_if;
    import art_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface art_cfg_if;
    import art_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/art_ctrl.sv -----
// Sequencing state machine of the acked route transmit tracker
`default_nettype none
module art_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire art_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output art_pkg::t_cmd      o_cmd
);
    import art_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SERVE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_tick) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_SERVE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SERVE: begin
                if (i_sts.serve_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.serve = 1'b1;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.out_pop = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`include "acked_route_transmit_tracker_macros.svh"

    `ART_ASSERT_NEXT(a_load_exec, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_EXEC, "accepted beat did not start execution")
    `ART_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_out_valid && i_out_ready && i_sts.out_last, o_in_ready, "final result beat did not return to idle")
    `ART_ASSERT_SAME(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input taken while results pending")

endmodule
`default_nettype wire

// ----- design/art_dpath.sv -----
// Route table, scan counters and result buffer of the acked route transmit tracker
`default_nettype none
module art_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire art_pkg::t_cmd i_cmd,
    input  wire art_pkg::t_in  i_in_data,
    input  wire logic          i_cfg_we,
    input  wire art_pkg::t_cfg i_cfg_data,
    output art_pkg::t_sts      o_sts,
    output art_pkg::t_out      o_out_data
);
    import art_pkg::*;

    logic [1:0]  r_status [ROUTES];
    logic        r_mode   [ROUTES];
    logic [31:0] r_tmo    [ROUTES];
    logic [31:0] r_sent   [ROUTES];
    logic [7:0]  r_tag    [ROUTES];
    logic [9:0]  r_plen   [ROUTES];
    logic [1:0]  n_status [ROUTES];
    logic        n_mode   [ROUTES];
    logic [31:0] n_tmo    [ROUTES];
    logic [31:0] n_sent   [ROUTES];
    logic [7:0]  n_tag    [ROUTES];
    logic [9:0]  n_plen   [ROUTES];

    logic [2:0]  r_total, n_total;
    logic [1:0]  r_last, n_last;
    logic [7:0]  r_next_tag, n_next_tag;
    logic [9:0]  r_stored, n_stored;
    logic [10:0] r_max_data, r_max_pkt;

    t_in         r_req, n_req;
    logic [1:0]  r_ptr, n_ptr;
    logic [2:0]  r_i, n_i;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_j, n_j;
    logic [2:0]  r_n, n_n;
    logic [1:0]  r_k, n_k;
    logic [2:0]  r_slots, n_slots;
    logic [1:0]  r_list [MAX_OUT];
    logic [1:0]  n_list [MAX_OUT];
    t_out        r_buf  [MAX_OUT];
    t_out        n_buf  [MAX_OUT];

    logic        all_idle;
    logic        serve_done;
    logic [1:0]  scan_nxt;

    always_comb begin
        all_idle = 1'b1;
        for (int r = 0; r < ROUTES; r++) begin
            if (3'(r) < r_total && r_status[r] != TX_IDLE) begin
                all_idle = 1'b0;
            end
        end
    end

    assign scan_nxt   = ({1'b0, r_ptr} + 3'd1 >= r_total) ? 2'd0 : r_ptr + 2'd1;
    assign serve_done = (r_j >= r_cnt) || (r_n == OUT_CAP) || (r_slots == 3'd0);

    assign o_sts.is_tick    = (r_req.func == FN_TICK);
    assign o_sts.scan_done  = (r_i == r_total);
    assign o_sts.serve_done = serve_done;
    assign o_sts.out_last   = ({1'b0, r_k} + 3'd1 == r_n);

    always_comb begin
        o_out_data                = r_buf[r_k];
        o_out_data.clear_to_write = all_idle;
        o_out_data.last           = o_sts.out_last;
    end

    always_comb begin
        logic        ok;
        logic        found;
        logic [1:0]  hit;
        logic [1:0]  q;
        logic [1:0]  st;
        logic [11:0] need;
        t_out        res;

        n_status   = r_status;
        n_mode     = r_mode;
        n_tmo      = r_tmo;
        n_sent     = r_sent;
        n_tag      = r_tag;
        n_plen     = r_plen;
        n_total    = r_total;
        n_last     = r_last;
        n_next_tag = r_next_tag;
        n_stored   = r_stored;
        n_req      = r_req;
        n_ptr      = r_ptr;
        n_i        = r_i;
        n_cnt      = r_cnt;
        n_j        = r_j;
        n_n        = r_n;
        n_k        = r_k;
        n_slots    = r_slots;
        n_list     = r_list;
        n_buf      = r_buf;
        ok         = 1'b0;
        found      = 1'b0;
        hit        = 2'd0;
        q          = r_list[r_j[1:0]];
        st         = r_status[scan_nxt];
        need       = 12'(r_stored) + 12'(r_plen[q]) + 12'(HEADER_BYTES);
        res        = '0;

        if (i_cmd.load) begin
            n_req   = i_in_data;
            n_ptr   = r_last;
            n_i     = 3'd0;
            n_cnt   = 3'd0;
            n_j     = 3'd0;
            n_n     = 3'd0;
            n_k     = 2'd0;
            n_slots = i_in_data.slots_free;
        end

        if (i_cmd.exec) begin
            unique case (r_req.func)
                FN_WRITE: begin
                    ok = ({1'b0, r_req.data_len} <= r_max_data);
                    if (ok) begin
                        n_stored = r_req.data_len;
                        for (int r = 0; r < ROUTES; r++) begin
                            if (3'(r) < r_total) begin
                                n_status[r] = (r_status[r] == TX_WAIT) ? TX_WAIT_FRESH
                                                                        : TX_FRESH;
                            end
                        end
                    end
                    res.op_ok = ok;
                end
                FN_ACK: begin
                    for (int r = 0; r < ROUTES; r++) begin
                        if (!found && 3'(r) < r_total && r_tag[r] == r_req.ack_tag) begin
                            found = 1'b1;
                            hit   = 2'(r);
                        end
                    end
                    if (found) begin
                        if (r_status[hit] == TX_WAIT) begin
                            n_status[hit] = TX_IDLE;
                        end else if (r_status[hit] == TX_WAIT_FRESH) begin
                            n_status[hit] = TX_FRESH;
                        end
                    end
                    res.result_route = hit;
                end
                FN_ADD: begin
                    if (r_total < ROUTE_CAP) begin
                        q            = r_total[1:0];
                        n_status[q]  = TX_IDLE;
                        n_mode[q]    = r_req.route_mode;
                        n_tmo[q]     = r_req.route_timeout;
                        n_sent[q]    = 32'd0;
                        n_tag[q]     = 8'd0;
                        n_plen[q]    = r_req.path_len;
                        n_total      = r_total + 3'd1;
                        res.result_route = q;
                        res.op_ok        = 1'b1;
                        res.new_index    = q;
                    end
                end
                FN_REMOVE: begin
                    res.result_route = r_req.route_index;
                    if ({1'b0, r_req.route_index} < r_total) begin
                        for (int r = 0; r < ROUTES - 1; r++) begin
                            if (2'(r) >= r_req.route_index && 3'(r + 1) < r_total) begin
                                n_status[r] = r_status[r + 1];
                                n_mode[r]   = r_mode[r + 1];
                                n_tmo[r]    = r_tmo[r + 1];
                                n_sent[r]   = r_sent[r + 1];
                                n_tag[r]    = r_tag[r + 1];
                                n_plen[r]   = r_plen[r + 1];
                            end
                        end
                        for (int r = 0; r < ROUTES; r++) begin
                            if (3'(r) + 3'd1 == r_total) begin
                                n_status[r] = TX_IDLE;
                                n_mode[r]   = 1'b0;
                                n_tmo[r]    = 32'd0;
                                n_sent[r]   = 32'd0;
                                n_tag[r]    = 8'd0;
                                n_plen[r]   = 10'd0;
                            end
                        end
                        n_total   = r_total - 3'd1;
                        res.op_ok = 1'b1;
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
            n_buf[0] = res;
            n_n      = 3'd1;
        end

        if (i_cmd.scan) begin
            n_i   = r_i + 3'd1;
            n_ptr = scan_nxt;
            if (st == TX_FRESH) begin
                n_list[r_cnt[1:0]] = scan_nxt;
                n_cnt              = r_cnt + 3'd1;
            end else if (st == TX_WAIT || st == TX_WAIT_FRESH) begin
                if (r_req.now_ms - r_sent[scan_nxt] >= r_tmo[scan_nxt]) begin
                    n_status[scan_nxt] = (st == TX_WAIT) ? TX_IDLE : TX_FRESH;
                end
            end
        end

        if (i_cmd.serve) begin
            n_j = r_j + 3'd1;
            res.result_route = q;
            if (need >= {1'b0, r_max_pkt}) begin
                n_status[q]       = TX_IDLE;
                res.oversize_drop = 1'b1;
            end else begin
                n_slots         = r_slots - 3'd1;
                res.transmitted = 1'b1;
                if (r_mode[q]) begin
                    n_tag[q]      = r_next_tag;
                    res.with_tag  = 1'b1;
                    res.tag_value = r_next_tag;
                    n_next_tag    = r_next_tag + 8'd1;
                end
                n_sent[q]   = r_req.now_ms;
                n_status[q] = TX_WAIT;
                n_last      = q;
            end
            n_buf[r_n[1:0]] = res;
            n_n             = r_n + 3'd1;
        end

        if (i_cmd.finish && r_n == 3'd0) begin
            n_buf[0] = '0;
            n_n      = 3'd1;
        end

        if (i_cmd.out_pop) begin
            n_k = r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROUTES; r++) begin
                r_status[r] <= TX_IDLE;
            end
            r_total    <= 3'd0;
            r_last     <= 2'd0;
            r_next_tag <= 8'd0;
            r_stored   <= 10'd0;
            r_max_data <= MAX_DATA_RST;
            r_max_pkt  <= MAX_PACKET_RST;
            r_i        <= 3'd0;
            r_cnt      <= 3'd0;
            r_j        <= 3'd0;
            r_n        <= 3'd0;
            r_k        <= 2'd0;
            r_slots    <= 3'd0;
        end else begin
            r_status   <= n_status;
            r_total    <= n_total;
            r_last     <= n_last;
            r_next_tag <= n_next_tag;
            r_stored   <= n_stored;
            r_i        <= n_i;
            r_cnt      <= n_cnt;
            r_j        <= n_j;
            r_n        <= n_n;
            r_k        <= n_k;
            r_slots    <= n_slots;
            if (i_cfg_we) begin
                unique case (i_cfg_data.idx)
                    CFG_MAX_DATA:   r_max_data <= i_cfg_data.wdata;
                    CFG_MAX_PACKET: r_max_pkt  <= i_cfg_data.wdata;
                    default:        r_max_data <= r_max_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_tmo  <= n_tmo;
        r_sent <= n_sent;
        r_tag  <= n_tag;
        r_plen <= n_plen;
        r_req  <= n_req;
        r_ptr  <= n_ptr;
        r_list <= n_list;
        r_buf  <= n_buf;
    end

endmodule
`default_nettype wire

// ----- design/acked_route_transmit_tracker.sv -----
// Top level of the acked route transmit tracker
// Tracks the transmit state of up to four outgoing routes. One input beat is
// taken at a time; the input channel stays not ready until every result beat
// of the previous item has been taken. Write, ack, add and remove return a
// single result beat. A dispatch tick walks the route table one entry per
// cycle (timeout check and fresh collection), then serves one collected
// route per cycle and returns one result beat per served route (a single
// empty beat if none). Configuration writes are taken in any cycle.
`default_nettype none
module acked_route_transmit_tracker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    art_in_if.sink    i_in,
    art_out_if.source o_out,
    art_cfg_if.sink   i_cfg
);
    import art_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    art_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    art_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in.data),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_sts      (sts),
        .o_out_data (o_out.data)
    );

endmodule
`default_nettype wire

// ----- test/acked_route_transmit_tracker_test.sv -----
// Testbench for the acked route transmit tracker: directed and random event checks
`default_nettype none
module acked_route_transmit_tracker_test;
    import art_pkg::*;

    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    art_in_if  in_ch();
    art_out_if out_ch();
    art_cfg_if cfg_ch();

    acked_route_transmit_tracker DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg(cfg_ch)
    );

    // route table mirror
    logic [1:0]  rt_state [ROUTES];
    logic        rt_acked [ROUTES];
    logic [31:0] rt_timeout [ROUTES];
    logic [31:0] rt_sent [ROUTES];
    logic [7:0]  rt_tag [ROUTES];
    logic [9:0]  rt_plen [ROUTES];
    int          rt_count;
    int          rr_last;
    logic [7:0]  tag_ctr;
    logic [9:0]  data_len_q;
    logic [10:0] lim_data;
    logic [10:0] lim_packet;

    t_out expected_beats [$];
    bit   failed = 1'b0;
    int   cycle_cnt = 0;
    bit   gaps_on = 1'b1;
    bit   stalls_on = 1'b1;
    int   hold_cycles = 0;
    int   stall_left = 0;
    logic [31:0] clock_ms = 32'd0;

    function automatic void clear_route(int r);
        rt_state[r] = TX_IDLE;
        rt_acked[r] = 1'b0;
        rt_timeout[r] = '0;
        rt_sent[r] = '0;
        rt_tag[r] = '0;
        rt_plen[r] = '0;
    endfunction

    function automatic void table_reset();
        for (int r = 0; r < ROUTES; r++) clear_route(r);
        rt_count = 0;
        rr_last = 0;
        tag_ctr = '0;
        data_len_q = '0;
        lim_data = MAX_DATA_RST;
        lim_packet = MAX_PACKET_RST;
    endfunction

    function automatic void predict_event(t_in it);
        t_out res [$];
        t_out o;
        int total;
        int r;
        int q;
        int cnt;
        int slots;
        int coll [ROUTES];
        bit idle;
        total = rt_count;
        cnt = 0;
        o = '0;
        case (it.func)
            FN_WRITE: begin
                if (it.data_len <= lim_data) begin
                    o.op_ok = 1'b1;
                    data_len_q = it.data_len;
                    for (r = 0; r < total; r++)
                        rt_state[r] = (rt_state[r] == TX_WAIT) ? TX_WAIT_FRESH : TX_FRESH;
                end
                res.push_back(o);
            end
            FN_TICK: begin
                r = rr_last;
                for (int i = 0; i < total; i++) begin
                    r++;
                    if (r >= total) r = 0;
                    if (rt_state[r] == TX_FRESH) begin
                        coll[cnt] = r;
                        cnt++;
                    end else if (rt_state[r] == TX_WAIT || rt_state[r] == TX_WAIT_FRESH) begin
                        if (32'(it.now_ms - rt_sent[r]) >= rt_timeout[r])
                            rt_state[r] = (rt_state[r] == TX_WAIT) ? TX_IDLE : TX_FRESH;
                    end
                end
                slots = it.slots_free;
                for (int i = 0; i < cnt && res.size() < MAX_OUT; i++) begin
                    q = coll[i];
                    if (slots == 0) break;
                    o = '0;
                    o.result_route = q[1:0];
                    if (int'(data_len_q) + int'(rt_plen[q]) + HEADER_BYTES >= int'(lim_packet))
                    begin
                        rt_state[q] = TX_IDLE;
                        o.oversize_drop = 1'b1;
                    end else begin
                        slots--;
                        o.transmitted = 1'b1;
                        if (rt_acked[q]) begin
                            rt_tag[q] = tag_ctr;
                            o.with_tag = 1'b1;
                            o.tag_value = tag_ctr;
                            tag_ctr = tag_ctr + 8'd1;
                        end
                        rt_sent[q] = it.now_ms;
                        rt_state[q] = TX_WAIT;
                        rr_last = q;
                    end
                    res.push_back(o);
                end
                if (res.size() == 0) begin
                    o = '0;
                    res.push_back(o);
                end
            end
            FN_ACK: begin
                for (r = 0; r < total; r++) begin
                    if (rt_tag[r] == it.ack_tag) begin
                        if (rt_state[r] == TX_WAIT) rt_state[r] = TX_IDLE;
                        else if (rt_state[r] == TX_WAIT_FRESH) rt_state[r] = TX_FRESH;
                        o.result_route = r[1:0];
                        break;
                    end
                end
                res.push_back(o);
            end
            FN_ADD: begin
                if (rt_count < ROUTES) begin
                    q = rt_count;
                    clear_route(q);
                    rt_acked[q] = it.route_mode;
                    rt_timeout[q] = it.route_timeout;
                    rt_plen[q] = it.path_len;
                    rt_count = q + 1;
                    o.result_route = q[1:0];
                    o.op_ok = 1'b1;
                    o.new_index = q[1:0];
                end
                res.push_back(o);
            end
            FN_REMOVE: begin
                o.result_route = it.route_index;
                if (int'(it.route_index) < total) begin
                    for (r = int'(it.route_index); r + 1 < total; r++) begin
                        rt_state[r] = rt_state[r+1];
                        rt_acked[r] = rt_acked[r+1];
                        rt_timeout[r] = rt_timeout[r+1];
                        rt_sent[r] = rt_sent[r+1];
                        rt_tag[r] = rt_tag[r+1];
                        rt_plen[r] = rt_plen[r+1];
                    end
                    clear_route(total - 1);
                    rt_count = total - 1;
                    o.op_ok = 1'b1;
                end
                res.push_back(o);
            end
            default: res.push_back(o);
        endcase
        idle = 1'b1;
        for (r = 0; r < rt_count; r++)
            if (rt_state[r] != TX_IDLE) idle = 1'b0;
        foreach (res[k]) res[k].clear_to_write = idle;
        res[res.size()-1].last = 1'b1;
        foreach (res[k]) expected_beats.push_back(res[k]);
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // check each result beat
    always @(posedge clk) begin
        t_out e;
        t_out a;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (expected_beats.size() == 0) begin
                $error("result beat with no expectation: %p", a);
                failed = 1'b1;
            end else begin
                e = expected_beats.pop_front();
                if (a !== e) begin
                    failed = 1'b1;
                    if (a.result_route !== e.result_route)
                        $error("result_route exp %0d got %0d", e.result_route, a.result_route);
                    if (a.transmitted !== e.transmitted)
                        $error("transmitted exp %0d got %0d", e.transmitted, a.transmitted);
                    if (a.with_tag !== e.with_tag)
                        $error("with_tag exp %0d got %0d", e.with_tag, a.with_tag);
                    if (a.tag_value !== e.tag_value)
                        $error("tag_value exp %0d got %0d", e.tag_value, a.tag_value);
                    if (a.oversize_drop !== e.oversize_drop)
                        $error("oversize_drop exp %0d got %0d", e.oversize_drop, a.oversize_drop);
                    if (a.op_ok !== e.op_ok)
                        $error("op_ok exp %0d got %0d", e.op_ok, a.op_ok);
                    if (a.new_index !== e.new_index)
                        $error("new_index exp %0d got %0d", e.new_index, a.new_index);
                    if (a.clear_to_write !== e.clear_to_write)
                        $error("clear_to_write exp %0d got %0d", e.clear_to_write,
                               a.clear_to_write);
                    if (a.last !== e.last)
                        $error("last exp %0d got %0d", e.last, a.last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** acked_route_transmit_tracker: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (stalls_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
                out_ch.ready <= (stall_left == 0);
            end
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_beat(t_in it);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge clk); while (!in_ch.ready);
        predict_event(it);
        @(negedge clk);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{idx: idx, wdata: val};
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_MAX_DATA) lim_data = val;
        else lim_packet = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // drop the input and wait until every expected beat has been taken
    task automatic settle();
        in_ch.valid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic t_in any_fields(logic [2:0] f);
        t_in it;
        it.func = f;
        it.data_len = 10'($urandom);
        it.now_ms = $urandom;
        it.slots_free = 3'($urandom_range(0, 4));
        it.ack_tag = 8'($urandom);
        it.route_mode = 1'($urandom);
        it.route_timeout = $urandom;
        it.path_len = 10'($urandom);
        it.route_index = 2'($urandom);
        return it;
    endfunction

    task automatic do_write(logic [9:0] len);
        t_in it;
        it = any_fields(FN_WRITE);
        it.data_len = len;
        send_beat(it);
    endtask

    task automatic do_tick(logic [31:0] now, logic [2:0] slots);
        t_in it;
        it = any_fields(FN_TICK);
        it.now_ms = now;
        it.slots_free = slots;
        send_beat(it);
    endtask

    task automatic do_ack(logic [7:0] tag);
        t_in it;
        it = any_fields(FN_ACK);
        it.ack_tag = tag;
        send_beat(it);
    endtask

    task automatic do_add(logic mode, logic [31:0] tmo, logic [9:0] plen);
        t_in it;
        it = any_fields(FN_ADD);
        it.route_mode = mode;
        it.route_timeout = tmo;
        it.path_len = plen;
        send_beat(it);
    endtask

    task automatic do_remove(logic [1:0] idx);
        t_in it;
        it = any_fields(FN_REMOVE);
        it.route_index = idx;
        send_beat(it);
    endtask

    task automatic test_route_table();
        do_tick(32'd0, 3'd4);
        do_add(1'b1, 32'd10, 10'd0);
        do_add(1'b0, 32'd0, 10'd1023);
        do_add(1'b1, 32'hFFFF_FFFF, 10'd5);
        do_add(1'b1, 32'd20, 10'd100);
        do_add(1'b0, 32'd1, 10'd1);
        do_remove(2'd3);
        do_remove(2'd3);
        do_add(1'b1, 32'd20, 10'd100);
    endtask

    task automatic test_write_and_tick();
        do_write(10'd1023);
        do_write(10'd128);
        do_write(10'd0);
        do_tick(32'd5, 3'd0);
        do_tick(32'd5, 3'd4);
        do_tick(32'd14, 3'd1);
        do_tick(32'd15, 3'd2);
        do_write(10'd20);
        do_tick(32'hFFFF_FFF0, 3'd4);
        do_ack(8'd1);
        do_ack(8'd0);
        do_ack(8'd255);
        do_tick(32'd6, 3'd4);
        do_tick(32'd40, 3'd4);
        send_beat(any_fields(FN_SPARE_LO));
        send_beat(any_fields(FN_SPARE_HI));
        do_remove(2'd0);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(CFG_MAX_PACKET, 11'd1);
        write_reg(CFG_MAX_DATA, 11'd1024);
        do_write(10'd1023);
        do_tick(32'd100, 3'd4);
        settle();
        write_reg(CFG_MAX_PACKET, 11'd1024);
        write_reg(CFG_MAX_DATA, 11'd1);
        do_write(10'd2);
        do_write(10'd1);
        do_tick(32'd200, 3'd4);
        settle();
    endtask

    task automatic random_events(int count);
        t_in it;
        int p;
        for (int n = 0; n < count; n++) begin
            clock_ms = ($urandom_range(0, 30) == 0) ? $urandom
                                                   : clock_ms + $urandom_range(0, 60);
            p = $urandom_range(0, 99);
            if (rt_count == 0 && p < 60) p = 80;
            if (p < 20) begin
                it = any_fields(FN_WRITE);
                if ($urandom_range(0, 7) != 0)
                    it.data_len = 10'($urandom_range(0, (lim_data > 1023) ? 1023 : lim_data));
            end else if (p < 55) begin
                it = any_fields(FN_TICK);
                it.now_ms = clock_ms;
            end else if (p < 75) begin
                it = any_fields(FN_ACK);
                if ($urandom_range(0, 9) < 7) it.ack_tag = rt_tag[$urandom_range(0, ROUTES-1)];
            end else if (p < 87) begin
                it = any_fields(FN_ADD);
                if ($urandom_range(0, 4) != 0) begin
                    it.route_timeout = $urandom_range(0, 120);
                    it.path_len = 10'($urandom_range(0, 80));
                end
            end else if (p < 96) begin
                it = any_fields(FN_REMOVE);
            end else begin
                it = any_fields(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)));
            end
            send_beat(it);
        end
    endtask

    task automatic test_random();
        random_events(60);
        settle();
        write_reg(CFG_MAX_DATA, 11'($urandom_range(1, 1024)));
        write_reg(CFG_MAX_PACKET, 11'($urandom_range(1, 1024)));
        random_events(60);
        settle();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        write_reg(CFG_MAX_DATA, 11'd1024);
        write_reg(CFG_MAX_PACKET, 11'd1024);
        random_events(50);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        settle();
        write_reg(CFG_MAX_DATA, MAX_DATA_RST);
        write_reg(CFG_MAX_PACKET, MAX_PACKET_RST);
        random_events(60);
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        random_events(12);
    endtask

    initial begin
        table_reset();
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_route_table();
        test_write_and_tick();
        test_register_extremes();
        test_random();
        test_backpressure();
        in_ch.valid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (20) @(posedge clk);
        if (!failed) begin
            $display("** acked_route_transmit_tracker: PASSED **");
        end else begin
            $display("** acked_route_transmit_tracker: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
